// ===== hw/rtl/qrm_pkg.sv =====
// Package for the quaternion to rotation matrix block: item types and constants.
// Used by quaternion_to_rotation_matrix; depends on nothing else.
package qrm_pkg;

    localparam int unsigned QW       = 16;          // width of a Q1.14 component
    localparam int unsigned FRAC     = 14;          // fraction bits of Q1.14
    localparam int unsigned PW       = 2 * QW;      // exact product width, Q2.28
    localparam int unsigned SW       = PW + 2;      // sum width before rounding
    localparam int unsigned RW       = SW - FRAC;   // width after dropping fraction

    // Rounding offset (one half LSB of Q1.14 at scale 2^28).
    localparam logic signed [SW-1:0] HALF_LSB = SW'(64'sd1 <<< (FRAC - 1));
    // The constant one of the diagonal entries, at scale 2^28, with the offset folded in.
    localparam logic signed [SW-1:0] ONE_HALF = SW'((64'sd1 <<< (2 * FRAC))
                                                    + (64'sd1 <<< (FRAC - 1)));

    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    typedef struct packed {
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic signed [QW-1:0] quat_w;
    } quat_t;

    typedef struct packed {
        logic signed [QW-1:0] m00;
        logic signed [QW-1:0] m01;
        logic signed [QW-1:0] m02;
        logic signed [QW-1:0] m10;
        logic signed [QW-1:0] m11;
        logic signed [QW-1:0] m12;
        logic signed [QW-1:0] m20;
        logic signed [QW-1:0] m21;
        logic signed [QW-1:0] m22;
        logic                 clipped;
    } mat_t;

endpackage

// ===== hw/rtl/quaternion_to_rotation_matrix.sv =====
// An accepted item passes through the input, product, sum and result registers in turn and shows on result with done.
// Throughput: one item per cycle; busy is always low, since nothing downstream can stall.
// The four stages are input register, multipliers, adders, rounding and saturation.
// Reset clears only the valid bits of the stages; payload registers are not reset.
// Nine 16x16 multipliers work in parallel in the second stage and set the clock period.
module quaternion_to_rotation_matrix (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  qrm_pkg::quat_t quat,
    output logic          done,
    output qrm_pkg::mat_t result
);
    import qrm_pkg::*;

    // Stage 1: the incoming item is captured.
    logic  v1_reg;
    quat_t q_reg;

    // Stage 2: the nine distinct products, each exact in Q2.28.
    logic                 v2_reg;
    logic signed [PW-1:0] p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [PW-1:0] p_xy_reg, p_xz_reg, p_yz_reg;
    logic signed [PW-1:0] p_wx_reg, p_wy_reg, p_wz_reg;

    // Stage 3: the nine entries summed exactly, with the half-LSB rounding offset added.
    logic                 v3_reg;
    logic signed [SW-1:0] s_reg  [9];
    logic signed [SW-1:0] s_next [9];

    // Stage 4: rounded, saturated entries.
    logic done_reg;
    mat_t result_reg;
    mat_t result_next;

    // Twice a product, sign extended to the sum width.
    function automatic logic signed [SW-1:0] dbl(input logic signed [PW-1:0] p);
        return $signed({p[PW-1], p, 1'b0});
    endfunction

    // Drops the fraction (an arithmetic shift floors), then clamps to 16 bits.
    // The top bit of the return value tells whether the entry was clamped.
    function automatic logic [QW:0] round_sat(input logic signed [SW-1:0] s);
        logic signed [RW-1:0] r;
        logic                 fits;
        r    = s[SW-1:FRAC];
        fits = (r[RW-1:QW-1] == '0) || (r[RW-1:QW-1] == '1);
        if (fits) begin
            return {1'b0, r[QW-1:0]};
        end
        else if (r[RW-1]) begin
            return {1'b1, Q_MIN};
        end
        else begin
            return {1'b1, Q_MAX};
        end
    endfunction

    assign busy = 1'b0;

    // Valid bits travel with the items.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (start && !busy) begin
            q_reg <= quat;
        end
    end

    always_ff @(posedge clk) begin
        if (v1_reg) begin
            p_xx_reg <= q_reg.quat_x * q_reg.quat_x;
            p_yy_reg <= q_reg.quat_y * q_reg.quat_y;
            p_zz_reg <= q_reg.quat_z * q_reg.quat_z;
            p_xy_reg <= q_reg.quat_x * q_reg.quat_y;
            p_xz_reg <= q_reg.quat_x * q_reg.quat_z;
            p_yz_reg <= q_reg.quat_y * q_reg.quat_z;
            p_wx_reg <= q_reg.quat_w * q_reg.quat_x;
            p_wy_reg <= q_reg.quat_w * q_reg.quat_y;
            p_wz_reg <= q_reg.quat_w * q_reg.quat_z;
        end
    end

    // Entries in row-major order. The wx terms carry the signs of the standard matrix.
    always_comb begin
        s_next[0] = ONE_HALF - dbl(p_yy_reg) - dbl(p_zz_reg);
        s_next[1] = HALF_LSB + dbl(p_xy_reg) - dbl(p_wz_reg);
        s_next[2] = HALF_LSB + dbl(p_xz_reg) + dbl(p_wy_reg);
        s_next[3] = HALF_LSB + dbl(p_xy_reg) + dbl(p_wz_reg);
        s_next[4] = ONE_HALF - dbl(p_xx_reg) - dbl(p_zz_reg);
        s_next[5] = HALF_LSB + dbl(p_yz_reg) - dbl(p_wx_reg);
        s_next[6] = HALF_LSB + dbl(p_xz_reg) - dbl(p_wy_reg);
        s_next[7] = HALF_LSB + dbl(p_yz_reg) + dbl(p_wx_reg);
        s_next[8] = ONE_HALF - dbl(p_xx_reg) - dbl(p_yy_reg);
    end

    always_ff @(posedge clk) begin
        if (v2_reg) begin
            for (int i = 0; i < 9; i++) begin
                s_reg[i] <= s_next[i];
            end
        end
    end

    always_comb begin
        logic [QW:0] e [9];
        for (int i = 0; i < 9; i++) begin
            e[i] = round_sat(s_reg[i]);
        end
        result_next.m00     = e[0][QW-1:0];
        result_next.m01     = e[1][QW-1:0];
        result_next.m02     = e[2][QW-1:0];
        result_next.m10     = e[3][QW-1:0];
        result_next.m11     = e[4][QW-1:0];
        result_next.m12     = e[5][QW-1:0];
        result_next.m20     = e[6][QW-1:0];
        result_next.m21     = e[7][QW-1:0];
        result_next.m22     = e[8][QW-1:0];
        result_next.clipped = e[0][QW] | e[1][QW] | e[2][QW] | e[3][QW] | e[4][QW]
                            | e[5][QW] | e[6][QW] | e[7][QW] | e[8][QW];
    end

    always_ff @(posedge clk) begin
        if (v3_reg) begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // An accepted item comes out on done once it has passed through every stage.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##4 done)
        else $error("accepted item did not come out after four cycles");

    // No result appears without a matching item accepted at the input.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without a matching accepted item");

    // A clipped result has at least one entry on a rail.
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.clipped |->
            (result.m00 == Q_MAX) || (result.m00 == Q_MIN) ||
            (result.m01 == Q_MAX) || (result.m01 == Q_MIN) ||
            (result.m02 == Q_MAX) || (result.m02 == Q_MIN) ||
            (result.m10 == Q_MAX) || (result.m10 == Q_MIN) ||
            (result.m11 == Q_MAX) || (result.m11 == Q_MIN) ||
            (result.m12 == Q_MAX) || (result.m12 == Q_MIN) ||
            (result.m20 == Q_MAX) || (result.m20 == Q_MIN) ||
            (result.m21 == Q_MAX) || (result.m21 == Q_MIN) ||
            (result.m22 == Q_MAX) || (result.m22 == Q_MIN))
        else $error("clipped set with no entry saturated");

    // The zero quaternion gives the identity matrix.
    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (quat == '0) |-> ##4
            done && !result.clipped &&
            (result.m00 == QW'(1 << FRAC)) && (result.m11 == QW'(1 << FRAC)) &&
            (result.m22 == QW'(1 << FRAC)) && (result.m01 == '0) &&
            (result.m02 == '0) && (result.m10 == '0) && (result.m12 == '0) &&
            (result.m20 == '0) && (result.m21 == '0))
        else $error("zero quaternion did not give the identity matrix");

endmodule
